// File: rtl/core/imptq_pkg.sv
// Package for the indexed max-priority task queue.
// Holds request/response structs, per-cell entry and control types, and codes.
// No dependencies.
`default_nettype none
package imptq_pkg;

  localparam int ID_W  = 20;
  localparam int PRI_W = 32;
  localparam int KEY_W = PRI_W + ID_W;

  // Command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_EDIT   = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_EXEC   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_DUP    = 2'd3;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [ID_W-1:0]  user_id;
    logic [ID_W-1:0]  task_id;
    logic [PRI_W-1:0] priority_req;
  } in_req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            found;
    logic [ID_W-1:0] user_out;
  } out_rsp_t;

  // One stored task
  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  task_id;
    logic [ID_W-1:0]  user_id;
    logic [PRI_W-1:0] prio;
  } entry_t;

  // Per-cycle operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_PROBE  = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_POP    = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [ID_W-1:0]  task_id;
    logic [ID_W-1:0]  user_id;
    logic [PRI_W-1:0] prio;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/imptq_cell.sv
// One cell of the sorted task chain: holds one entry, trades with its neighbors.
// Depends on imptq_pkg.
`default_nettype none
module imptq_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  imptq_pkg::cell_ctl_t ctl,
  input  imptq_pkg::entry_t   left_ent,
  input  wire                 left_ins,
  input  imptq_pkg::entry_t   right_ent,
  output imptq_pkg::entry_t   ent,
  output logic                ins,
  output logic                match
);

  imptq_pkg::entry_t ent_r, ent_nxt;
  logic ins_r, ins_nxt;
  logic match_r, match_nxt;
  logic [imptq_pkg::KEY_W-1:0] my_key, bc_key;

  assign my_key = {ent_r.prio, ent_r.task_id};
  assign bc_key = {ctl.prio, ctl.task_id};

  // Next entry and probe flags
  always_comb begin
    ent_nxt   = ent_r;
    ins_nxt   = ins_r;
    match_nxt = match_r;
    case (ctl.op)
      imptq_pkg::OP_PROBE: begin
        // insert point: empty or broadcast key ranks above mine
        ins_nxt   = !ent_r.valid || (bc_key > my_key);
        match_nxt = ent_r.valid && (ent_r.task_id == ctl.task_id);
      end
      imptq_pkg::OP_INSERT: begin
        if (left_ins) begin
          ent_nxt = left_ent;
        end else if (ins_r) begin
          ent_nxt.valid   = 1'b1;
          ent_nxt.task_id = ctl.task_id;
          ent_nxt.user_id = ctl.user_id;
          ent_nxt.prio    = ctl.prio;
        end
      end
      imptq_pkg::OP_DELETE: begin
        // cells at or behind the removed key close the gap
        if (ent_r.valid && (my_key <= bc_key)) begin
          ent_nxt = right_ent;
        end
      end
      imptq_pkg::OP_POP: begin
        ent_nxt = right_ent;
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
      ins_r       <= 1'b0;
      match_r     <= 1'b0;
    end else begin
      ent_r   <= ent_nxt;
      ins_r   <= ins_nxt;
      match_r <= match_nxt;
    end
  end

  assign ent   = ent_r;
  assign ins   = ins_r;
  assign match = match_r;

endmodule
`default_nettype wire

// File: rtl/core/indexed_max_priority_task_queue_unit.sv
// Top level of the indexed max-priority task queue: sequencer plus cell chain.
// Depends on imptq_pkg and imptq_cell.
//
// Usage:
//   A request (in_req: cmd, user_id, task_id, priority_req) is taken at a
//   rising edge with start high and busy low. Exactly one response per
//   request appears on out_rsp for one cycle, marked by out_valid; the
//   receiver cannot stall it, and the response register lets the next
//   request be taken in the same cycle the strobe is shown.
//   Tasks sit in a chain of CAPACITY cells kept sorted by (priority, task id),
//   largest first, so the top task is always in the head cell.
//   Steps from accept to the strobe, set by the sequencer's passes over
//   the chain (probe, reduce, shift):
//     execute top: head pop, whole chain shifts one cell
//     add, remove: probe, reduce on a fault; probe, reduce, shift otherwise
//     edit:        probe, reduce if absent; else delete pass then insert pass
//   One request is in flight at a time.
//   Reset (synchronous, active low) empties every cell at once and clears
//   the occupancy count; no clearing pass is needed.
`default_nettype none
module indexed_max_priority_task_queue_unit #(
  parameter int CAPACITY = 256
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  imptq_pkg::in_req_t   in_req,
  output logic                 busy,
  output logic                 out_valid,
  output imptq_pkg::out_rsp_t  out_rsp
);

  localparam int OCC_W = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_EXEC    = 6'b000010,
    S_PROBE   = 6'b000100,
    S_RESOLVE = 6'b001000,
    S_DELETE  = 6'b010000,
    S_INSERT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  imptq_pkg::in_req_t req_r, req_nxt;
  logic phase2_r, phase2_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [imptq_pkg::ID_W-1:0]  m_task_r, m_task_nxt, m_user_r, m_user_nxt;
  logic [imptq_pkg::PRI_W-1:0] m_prio_r, m_prio_nxt;
  imptq_pkg::out_rsp_t rsp_r, rsp_nxt;
  logic out_valid_r, out_valid_nxt;

  imptq_pkg::cell_ctl_t ctl;
  imptq_pkg::entry_t ent [CAPACITY];
  logic ins [CAPACITY];
  logic match [CAPACITY];

  localparam imptq_pkg::entry_t EMPTY_ENT = '0;

  // Cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    imptq_pkg::entry_t left_e, right_e;
    logic left_i;
    if (g == 0) begin : g_head
      assign left_e = EMPTY_ENT;
      assign left_i = 1'b0;
    end else begin : g_mid_l
      assign left_e = ent[g-1];
      assign left_i = ins[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_e = EMPTY_ENT;
    end else begin : g_mid_r
      assign right_e = ent[g+1];
    end
    imptq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .left_ent  (left_e),
      .left_ins  (left_i),
      .right_ent (right_e),
      .ent       (ent[g]),
      .ins       (ins[g]),
      .match     (match[g])
    );
  end

  // Match reduction: at most one cell matches, so an AND-OR mux picks it
  logic any_match;
  logic [imptq_pkg::ID_W-1:0]  sel_task, sel_user;
  logic [imptq_pkg::PRI_W-1:0] sel_prio;
  always_comb begin
    any_match = 1'b0;
    sel_task  = '0;
    sel_user  = '0;
    sel_prio  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_match = any_match | match[i];
      sel_task  = sel_task | ({imptq_pkg::ID_W{match[i]}} & ent[i].task_id);
      sel_user  = sel_user | ({imptq_pkg::ID_W{match[i]}} & ent[i].user_id);
      sel_prio  = sel_prio | ({imptq_pkg::PRI_W{match[i]}} & ent[i].prio);
    end
  end

  // Broadcast to the chain
  always_comb begin
    ctl.op      = imptq_pkg::OP_HOLD;
    ctl.task_id = req_r.task_id;
    ctl.prio    = req_r.priority_req;
    ctl.user_id = (req_r.cmd == imptq_pkg::CMD_EDIT) ? m_user_r : req_r.user_id;
    case (state_r)
      S_EXEC:   ctl.op = imptq_pkg::OP_POP;
      S_PROBE:  ctl.op = imptq_pkg::OP_PROBE;
      S_INSERT: ctl.op = imptq_pkg::OP_INSERT;
      S_DELETE: begin
        ctl.op      = imptq_pkg::OP_DELETE;
        ctl.task_id = m_task_r;
        ctl.prio    = m_prio_r;
      end
      default:  ctl.op = imptq_pkg::OP_HOLD;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    phase2_nxt    = phase2_r;
    occ_nxt       = occ_r;
    m_task_nxt    = m_task_r;
    m_user_nxt    = m_user_r;
    m_prio_nxt    = m_prio_r;
    rsp_nxt       = rsp_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt    = in_req;
          phase2_nxt = 1'b0;
          state_nxt  = (in_req.cmd == imptq_pkg::CMD_EXEC) ? S_EXEC : S_PROBE;
        end
      end
      S_EXEC: begin
        rsp_nxt.status   = imptq_pkg::ST_OK;
        rsp_nxt.found    = ent[0].valid;
        rsp_nxt.user_out = ent[0].valid ? ent[0].user_id : '0;
        if (ent[0].valid) begin
          occ_nxt = occ_r - OCC_W'(1);
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_PROBE: begin
        state_nxt = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (!phase2_r) begin
          // hold the matched entry; an edit's insert pass reuses its user
          m_task_nxt = sel_task;
          m_user_nxt = sel_user;
          m_prio_nxt = sel_prio;
        end
        rsp_nxt.found    = 1'b0;
        rsp_nxt.user_out = '0;
        rsp_nxt.status   = imptq_pkg::ST_OK;
        if (phase2_r) begin
          // second pass of an edit: slot freed by the delete pass
          state_nxt = S_INSERT;
        end else if (req_r.cmd == imptq_pkg::CMD_ADD) begin
          if (any_match) begin
            rsp_nxt.status = imptq_pkg::ST_DUP;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else if (occ_r == OCC_W'(CAPACITY)) begin
            rsp_nxt.status = imptq_pkg::ST_FULL;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_INSERT;
          end
        end else if (!any_match) begin
          rsp_nxt.status = imptq_pkg::ST_ABSENT;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_DELETE;
        end
      end
      S_DELETE: begin
        occ_nxt = occ_r - OCC_W'(1);
        if (req_r.cmd == imptq_pkg::CMD_EDIT) begin
          phase2_nxt = 1'b1;
          state_nxt  = S_PROBE;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_INSERT: begin
        occ_nxt       = occ_r + OCC_W'(1);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase2_r    <= 1'b0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase2_r    <= phase2_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    m_task_r <= m_task_nxt;
    m_user_r <= m_user_nxt;
    m_prio_r <= m_prio_nxt;
    rsp_r    <= rsp_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  // Checks
  a_rsp_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("response strobe while a request is in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not start the sequencer");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_head_occ: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (ent[0].valid == (occ_r != '0)))
    else $error("head cell disagrees with occupancy");

endmodule
`default_nettype wire
